FILE: rtl/core/crts_pkg.sv
`timescale 1ns / 1ps

package crts_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int FIELD_W   = 7;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_RUN    = 1'b1;

    localparam logic [ADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;
    localparam logic [FIELD_W-1:0] NODE_COUNT_RESET = FIELD_W'(MAX_ITEMS);

    typedef logic [MAX_ITEMS-1:0] t_row;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_REC_A,
        S_REC_B,
        S_REC_WB,
        S_CNT_RD,
        S_CNT_ACC,
        S_READY,
        S_PICK,
        S_UPD,
        S_OUT_RD,
        S_OUT_EM
    } t_state;

    typedef struct packed {
        logic load;
        logic run_init;
        logic idx_clr;
        logic idx_inc;
        logic mat_clr;
        logic rd_a;
        logic wr_a;
        logic wr_b;
        logic cnt_acc;
        logic ready_init;
        logic pick;
        logic upd;
        logic out_em;
    } t_cmd;

    typedef struct packed {
        logic rec_ok;
        logic idx_last;
        logic clr_last;
        logic ready_empty;
    } t_status;

    // Index of the highest item taking part in a run, with the count saturated to the range.
    function automatic logic [IDX_W-1:0] last_index(input logic [FIELD_W-1:0] count);
        logic [IDX_W-1:0] res;
        if (count == '0) begin
            res = '0;
        end else if (int'(count) > MAX_ITEMS) begin
            res = IDX_W'(MAX_ITEMS - 1);
        end else begin
            res = IDX_W'(count - FIELD_W'(1));
        end
        return res;
    endfunction

    // The lowest set bit is isolated with one add, then encoded.
    function automatic logic [IDX_W-1:0] lowest_index(input t_row vec);
        t_row             low;
        logic [IDX_W-1:0] idx;
        low = vec & (~vec + t_row'(1));
        idx = '0;
        for (int k = 0; k < MAX_ITEMS; k++) begin
            if (low[k]) begin
                idx = idx | IDX_W'(k);
            end
        end
        return idx;
    endfunction

    function automatic logic index_ok(input logic [FIELD_W-1:0] idx);
        return (idx != '0) && (int'(idx) <= MAX_ITEMS);
    endfunction

endpackage

FILE: rtl/core/crts_ctrl.sv
`timescale 1ns / 1ps

module crts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_opcode,
    input  crts_pkg::t_status i_status,
    output crts_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    crts_pkg::t_state r_state;
    crts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crts_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            crts_pkg::S_CLR: begin
                if (i_status.clr_last) begin
                    n_state = crts_pkg::S_IDLE;
                end
            end
            crts_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == crts_pkg::OP_RUN) begin
                        n_state = crts_pkg::S_CNT_RD;
                    end else begin
                        n_state = crts_pkg::S_REC_A;
                    end
                end
            end
            crts_pkg::S_REC_A: begin
                n_state = i_status.rec_ok ? crts_pkg::S_REC_B : crts_pkg::S_IDLE;
            end
            crts_pkg::S_REC_B:   n_state = crts_pkg::S_REC_WB;
            crts_pkg::S_REC_WB:  n_state = crts_pkg::S_IDLE;
            crts_pkg::S_CNT_RD:  n_state = crts_pkg::S_CNT_ACC;
            crts_pkg::S_CNT_ACC: begin
                n_state = i_status.idx_last ? crts_pkg::S_READY : crts_pkg::S_CNT_RD;
            end
            crts_pkg::S_READY:   n_state = crts_pkg::S_PICK;
            crts_pkg::S_PICK: begin
                n_state = i_status.ready_empty ? crts_pkg::S_OUT_RD : crts_pkg::S_UPD;
            end
            crts_pkg::S_UPD:     n_state = crts_pkg::S_PICK;
            crts_pkg::S_OUT_RD:  n_state = crts_pkg::S_OUT_EM;
            crts_pkg::S_OUT_EM: begin
                n_state = i_status.idx_last ? crts_pkg::S_CLR : crts_pkg::S_OUT_RD;
            end
            default:             n_state = crts_pkg::S_CLR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            crts_pkg::S_CLR: begin
                o_cmd.mat_clr = 1'b1;
                o_cmd.idx_inc = !i_status.clr_last;
            end
            crts_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == crts_pkg::OP_RUN) begin
                        o_cmd.run_init = 1'b1;
                        o_cmd.idx_clr  = 1'b1;
                    end
                end
            end
            crts_pkg::S_REC_A:   o_cmd.rd_a = i_status.rec_ok;
            crts_pkg::S_REC_B:   o_cmd.wr_a = 1'b1;
            crts_pkg::S_REC_WB:  o_cmd.wr_b = 1'b1;
            crts_pkg::S_CNT_RD:  o_cmd = '0;
            crts_pkg::S_CNT_ACC: begin
                o_cmd.cnt_acc = 1'b1;
                o_cmd.idx_inc = !i_status.idx_last;
            end
            crts_pkg::S_READY:   o_cmd.ready_init = 1'b1;
            crts_pkg::S_PICK: begin
                o_cmd.pick    = !i_status.ready_empty;
                o_cmd.idx_clr = i_status.ready_empty;
            end
            crts_pkg::S_UPD:     o_cmd.upd = 1'b1;
            crts_pkg::S_OUT_RD:  o_cmd = '0;
            crts_pkg::S_OUT_EM: begin
                o_cmd.out_em  = 1'b1;
                o_cmd.idx_clr = i_status.idx_last;
                o_cmd.idx_inc = !i_status.idx_last;
            end
            default:             o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/crts_dp.sv
`timescale 1ns / 1ps

module crts_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crts_pkg::t_cmd                    i_cmd,
    input  logic [crts_pkg::IDX_W-1:0]        i_last_idx,
    input  logic [crts_pkg::FIELD_W-1:0]      i_first_index,
    input  logic [crts_pkg::FIELD_W-1:0]      i_second_index,
    input  logic                              i_first_is_smaller,
    output crts_pkg::t_status                 o_status,
    output logic                              o_result_valid,
    output logic [crts_pkg::FIELD_W-1:0]      o_item_index,
    output logic [crts_pkg::FIELD_W-1:0]      o_rank,
    output logic                              o_cycle_found,
    output logic                              o_last
);

    crts_pkg::t_row r_mat [crts_pkg::MAX_ITEMS];
    crts_pkg::t_row r_mat_rd;
    logic [crts_pkg::CNT_W-1:0] r_rank_mem [crts_pkg::MAX_ITEMS];
    logic [crts_pkg::CNT_W-1:0] r_rank_rd;
    logic [crts_pkg::CNT_W-1:0] r_pend [crts_pkg::MAX_ITEMS];

    crts_pkg::t_row             r_ready;
    crts_pkg::t_row             r_placed;
    logic [crts_pkg::CNT_W-1:0] r_placed_count;
    logic [crts_pkg::IDX_W-1:0] r_idx;
    logic [crts_pkg::IDX_W-1:0] r_a;
    logic [crts_pkg::IDX_W-1:0] r_b;
    logic                       r_flag;
    logic                       r_rec_ok;

    logic                       r_out_valid;
    logic [crts_pkg::FIELD_W-1:0] r_out_item;
    logic [crts_pkg::FIELD_W-1:0] r_out_rank;
    logic                       r_out_cycle;
    logic                       r_out_last;

    crts_pkg::t_row             lane_en;
    crts_pkg::t_row             zero_mask;
    crts_pkg::t_row             done_mask;
    crts_pkg::t_row             pick_bit;
    crts_pkg::t_row             bit_a;
    crts_pkg::t_row             bit_b;
    crts_pkg::t_row             wdata;
    logic [crts_pkg::IDX_W-1:0] pick_idx;
    logic [crts_pkg::IDX_W-1:0] raddr;
    logic [crts_pkg::IDX_W-1:0] waddr;
    logic                       we;

    always_comb begin
        for (int v = 0; v < crts_pkg::MAX_ITEMS; v++) begin
            lane_en[v]   = crts_pkg::IDX_W'(v) <= i_last_idx;
            zero_mask[v] = lane_en[v] && (r_pend[v] == '0);
            done_mask[v] = lane_en[v] && r_mat_rd[v] && (r_pend[v] == crts_pkg::CNT_W'(1));
        end
    end

    assign pick_idx = crts_pkg::lowest_index(r_ready);
    assign pick_bit = crts_pkg::t_row'(1) << pick_idx;
    assign bit_a    = crts_pkg::t_row'(1) << r_a;
    assign bit_b    = crts_pkg::t_row'(1) << r_b;

    always_comb begin
        raddr = r_idx;
        if (i_cmd.rd_a) begin
            raddr = r_a;
        end else if (i_cmd.wr_a) begin
            raddr = r_b;
        end else if (i_cmd.pick) begin
            raddr = pick_idx;
        end
    end

    always_comb begin
        we    = i_cmd.wr_a || i_cmd.wr_b || i_cmd.mat_clr;
        waddr = r_idx;
        wdata = '0;
        if (i_cmd.wr_a) begin
            waddr = r_a;
            wdata = (r_mat_rd & ~bit_b) | (r_flag ? bit_b : '0);
        end else if (i_cmd.wr_b) begin
            waddr = r_b;
            wdata = (r_mat_rd & ~bit_a) | (r_flag ? '0 : bit_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mat[waddr] <= wdata;
        end
        r_mat_rd <= r_mat[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_rank_mem[pick_idx] <= r_placed_count + crts_pkg::CNT_W'(1);
        end
        r_rank_rd <= r_rank_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        for (int v = 0; v < crts_pkg::MAX_ITEMS; v++) begin
            if (i_cmd.run_init) begin
                r_pend[v] <= '0;
            end else if (i_cmd.cnt_acc && lane_en[v] && r_mat_rd[v]) begin
                r_pend[v] <= r_pend[v] + crts_pkg::CNT_W'(1);
            end else if (i_cmd.upd && lane_en[v] && r_mat_rd[v] && (r_pend[v] != '0)) begin
                r_pend[v] <= r_pend[v] - crts_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready        <= '0;
            r_placed       <= '0;
            r_placed_count <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.ready_init) begin
                r_ready        <= zero_mask;
                r_placed       <= '0;
                r_placed_count <= '0;
            end else if (i_cmd.pick) begin
                r_ready        <= r_ready & ~pick_bit;
                r_placed       <= r_placed | pick_bit;
                r_placed_count <= r_placed_count + crts_pkg::CNT_W'(1);
            end else if (i_cmd.upd) begin
                r_ready        <= r_ready | done_mask;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + crts_pkg::IDX_W'(1);
            end
            r_out_valid <= i_cmd.out_em;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a      <= crts_pkg::IDX_W'(i_first_index - crts_pkg::FIELD_W'(1));
            r_b      <= crts_pkg::IDX_W'(i_second_index - crts_pkg::FIELD_W'(1));
            r_flag   <= i_first_is_smaller;
            r_rec_ok <= crts_pkg::index_ok(i_first_index) && crts_pkg::index_ok(i_second_index)
                        && (i_first_index != i_second_index);
        end
        if (i_cmd.out_em) begin
            r_out_item  <= crts_pkg::FIELD_W'(r_idx) + crts_pkg::FIELD_W'(1);
            r_out_rank  <= r_placed[r_idx] ? crts_pkg::FIELD_W'(r_rank_rd) : '0;
            r_out_cycle <= crts_pkg::FIELD_W'(r_placed_count)
                           != (crts_pkg::FIELD_W'(i_last_idx) + crts_pkg::FIELD_W'(1));
            r_out_last  <= r_idx == i_last_idx;
        end
    end

    assign o_status.rec_ok      = r_rec_ok;
    assign o_status.idx_last    = r_idx == i_last_idx;
    assign o_status.clr_last    = r_idx == crts_pkg::IDX_W'(crts_pkg::MAX_ITEMS - 1);
    assign o_status.ready_empty = r_ready == '0;

    assign o_result_valid = r_out_valid;
    assign o_item_index   = r_out_item;
    assign o_rank         = r_out_rank;
    assign o_cycle_found  = r_out_cycle;
    assign o_last         = r_out_last;

    a_ready_not_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_placed) == '0)
        else $error("An item is both ready and already placed.");

    a_placed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crts_pkg::CNT_W'($countones(r_placed)) == r_placed_count)
        else $error("Placed count disagrees with the placed items.");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rank <= crts_pkg::FIELD_W'(r_placed_count)))
        else $error("Reported rank exceeds the number of placed items.");

    a_pick_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |=> r_placed[$past(pick_idx)] && !r_ready[$past(pick_idx)])
        else $error("A picked item was not moved from ready to placed.");

endmodule

FILE: rtl/core/comparison_rank_topological_sort.sv
`timescale 1ns / 1ps

// Records pairwise comparisons as edges of a bit matrix and, on a run command, ranks the
// items 1..node_count by a topological sort that always places the lowest-numbered ready
// item first. After reset a clearing pass over the 64 matrix rows holds busy high. A valid
// record command keeps busy high after the start beat through S_REC_A, S_REC_B and S_REC_WB
// (one read-modify-write of each of the two rows in the matrix); a record that is ignored,
// for an index out of range or the same item twice, keeps it high only through S_REC_A. A
// run holds busy high while it counts predecessors over each matrix row of the saturated
// node count, reads the placed item's row and updates the counts for each placement, reads
// each result from the rank memory, and makes a clearing pass over the matrix at the end.
// Results come in item order, each present for exactly one cycle with o_result_valid; the
// receiver cannot stall them and must take every one.
module comparison_rank_topological_sort (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic [crts_pkg::FIELD_W-1:0]       i_first_index,
    input  logic [crts_pkg::FIELD_W-1:0]       i_second_index,
    input  logic                               i_first_is_smaller,
    output logic                               o_result_valid,
    output logic [crts_pkg::FIELD_W-1:0]       o_item_index,
    output logic [crts_pkg::FIELD_W-1:0]       o_rank,
    output logic                               o_cycle_found,
    output logic                               o_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crts_pkg::ADDR_W-1:0]        paddr,
    input  logic [crts_pkg::DATA_W-1:0]        pwdata,
    output logic [crts_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [crts_pkg::FIELD_W-1:0] r_node_count;
    logic                         reg_hit;
    crts_pkg::t_cmd               cmd;
    crts_pkg::t_status            status;
    logic [crts_pkg::IDX_W-1:0]   last_idx;

    assign pready  = 1'b1;
    assign reg_hit = paddr[crts_pkg::ADDR_W-1:2] == crts_pkg::ADDR_NODE_COUNT[crts_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= crts_pkg::NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_node_count <= pwdata[crts_pkg::FIELD_W-1:0];
        end
    end

    assign prdata   = reg_hit ? crts_pkg::DATA_W'(r_node_count) : '0;
    assign last_idx = crts_pkg::last_index(r_node_count);

    crts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    crts_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_last_idx         (last_idx),
        .i_first_index      (i_first_index),
        .i_second_index     (i_second_index),
        .i_first_is_smaller (i_first_is_smaller),
        .o_status           (status),
        .o_result_valid     (o_result_valid),
        .o_item_index       (o_item_index),
        .o_rank             (o_rank),
        .o_cycle_found      (o_cycle_found),
        .o_last             (o_last)
    );

endmodule
